/* src/gga_pkg.sv */
// Package with constants, types and helper functions of the GGA sentence position decoder.
package gga_pkg;

  localparam int ScanLimit  = 128;
  localparam int FieldLimit = 14;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UP_S   = 8'h53;
  localparam logic [7:0] CHAR_LO_S   = 8'h73;
  localparam logic [7:0] CHAR_UP_W   = 8'h57;
  localparam logic [7:0] CHAR_LO_W   = 8'h77;
  localparam logic [7:0] CHAR_UP_K   = 8'h4B;
  localparam logic [7:0] CHAR_LO_K   = 8'h6B;

  localparam logic [2:0] HEADER_LEN = 3'd6;

  localparam logic [3:0] FIELD_TIME     = 4'd1;
  localparam logic [3:0] FIELD_LAT      = 4'd2;
  localparam logic [3:0] FIELD_LAT_HEMI = 4'd3;
  localparam logic [3:0] FIELD_LON      = 4'd4;
  localparam logic [3:0] FIELD_LON_HEMI = 4'd5;
  localparam logic [3:0] FIELD_ALT      = 4'd9;
  localparam logic [3:0] FIELD_ALT_UNIT = 4'd10;
  localparam logic [3:0] FIELDS_NEEDED  = 4'd10;

  localparam logic [2:0] TIME_DIGITS = 3'd6;

  localparam logic [1:0] STATUS_DECODED    = 2'd0;
  localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
  localparam logic [1:0] STATUS_SHORT      = 2'd2;

  localparam logic [29:0] ACC_MAX      = 30'd999999999;
  localparam int          MinuteScale  = 1000000;
  localparam logic [9:0]  DEG_MAX      = 10'd999;
  localparam logic [19:0] MIN_MAX      = 20'd999999;
  // Rounded-up 2^24 / 3, exact for dividends below 2^23.
  localparam logic [22:0] RECIP_THREE  = 23'd5592406;

  typedef struct packed {
    logic [9:0]  degrees;
    logic [19:0] minutes;
  } coord_t;

  function automatic logic [7:0] header_char(logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = CHAR_DOLLAR;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h47;
      3'd4:    ch = 8'h47;
      3'd5:    ch = 8'h41;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] digit_val(logic [7:0] ch);
    logic [7:0] diff;
    diff = ch - CHAR_ZERO;
    return (ch >= CHAR_ZERO && ch <= CHAR_NINE) ? diff[3:0] : 4'd0;
  endfunction

  // Appends a decimal digit to a value kept as degrees and millionths, saturating.
  function automatic coord_t coord_push(coord_t acc, logic [3:0] dig);
    logic [23:0] t;
    logic [3:0]  carry;
    logic [23:0] rem;
    logic [13:0] deg;
    coord_t      res;
    t     = {4'b0, acc.minutes} * 24'd10 + {20'b0, dig};
    carry = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (t >= 24'(k * MinuteScale)) carry = 4'(k);
    end
    rem = t - {20'b0, carry} * 24'(MinuteScale);
    deg = {4'b0, acc.degrees} * 14'd10 + {10'b0, carry};
    if (deg > {4'b0, DEG_MAX}) begin
      res.degrees = DEG_MAX;
      res.minutes = MIN_MAX;
    end else begin
      res.degrees = deg[9:0];
      res.minutes = rem[19:0];
    end
    return res;
  endfunction

  function automatic logic [29:0] acc_push(logic [29:0] acc, logic [3:0] dig);
    logic [33:0] t;
    t = {4'b0, acc} * 34'd10 + {30'b0, dig};
    return (t > {4'b0, ACC_MAX}) ? ACC_MAX : t[29:0];
  endfunction

  function automatic logic signed [30:0] signed_out(logic [39:0] mag, logic neg);
    logic [30:0] sat;
    sat = (mag > {10'b0, ACC_MAX}) ? {1'b0, ACC_MAX} : mag[30:0];
    return neg ? -sat : sat;
  endfunction

endpackage

/* src/gga_sentence_position_decoder_top.sv */
// Top level of the GGA sentence position decoder: byte parser and result pipeline.
//
// The slave stream (s_tvalid, s_tready, s_tdata) carries one received ASCII
// character per transaction. A '$' opens a sentence, the header must read
// $GPGGA, and commas step through the fields. A '*' inside a sentence closes
// it and produces one transaction on the master stream (m_tvalid, m_tready,
// m_tdata) holding a status, the UTC time as BCD, latitude and longitude in
// degrees times 10^6 and the integer altitude. No other byte gives a result.
// Every byte updates the parser state in the cycle it is accepted, so one
// byte is taken per cycle while s_tready is high. The result of a '*' is
// captured in the first stage, scaled by the multiplies in the second and
// summed, saturated and signed in the third, which drives m_tvalid.
// The three result stages form an elastic pipeline; when the receiver stalls,
// results wait in the stages, bytes keep flowing until all three hold a
// result, and then s_tready drops until m_tready frees a stage.
// A synchronous reset on rst leaves the parser outside any sentence and
// empties the pipeline.
module gga_sentence_position_decoder_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata    // status, utc_time_bcd, latitude, longitude, altitude, pad
);

  logic               in_sentence, in_sentence_next;
  logic [2:0]         header_pos, header_pos_next;
  logic               header_ok, header_ok_next;
  logic [3:0]         field_index, field_index_next;
  logic [7:0]         char_count, char_count_next;
  logic               field_first_char, field_first_char_next;
  logic [23:0]        time_shift, time_shift_next;
  logic [2:0]         time_digit_count, time_digit_count_next;
  logic               time_done, time_done_next;
  gga_pkg::coord_t    lat_accum, lat_accum_next;
  logic               lat_south, lat_south_next;
  gga_pkg::coord_t    lon_accum, lon_accum_next;
  logic               lon_west, lon_west_next;
  logic [29:0]        alt_accum, alt_accum_next;
  logic               alt_negative, alt_negative_next;
  logic               alt_done, alt_done_next;
  logic               alt_kilometre, alt_kilometre_next;

  logic               in_fire;
  logic               star_hit;
  logic [3:0]         digit;
  logic               ready1, ready2, ready3;
  logic [1:0]         status_now;

  logic               v1;
  logic [1:0]         p1_status;
  logic [23:0]        p1_time;
  gga_pkg::coord_t    p1_lat;
  logic               p1_lat_neg;
  gga_pkg::coord_t    p1_lon;
  logic               p1_lon_neg;
  logic [29:0]        p1_alt;
  logic               p1_alt_km;
  logic               p1_alt_neg;

  logic               v2;
  logic [1:0]         p2_status;
  logic [23:0]        p2_time;
  logic [29:0]        p2_lat_deg;
  logic [20:0]        p2_lat_frac;
  logic               p2_lat_neg;
  logic [29:0]        p2_lon_deg;
  logic [20:0]        p2_lon_frac;
  logic               p2_lon_neg;
  logic [39:0]        p2_alt;
  logic               p2_alt_neg;

  logic [22:0]        lat_x5, lon_x5;
  logic [45:0]        lat_prod, lon_prod;
  logic signed [30:0] lat_out, lon_out, alt_out;

  assign in_fire = s_tvalid && s_tready;
  assign digit   = gga_pkg::digit_val(s_tdata);

  always_comb begin
    in_sentence_next      = in_sentence;
    header_pos_next       = header_pos;
    header_ok_next        = header_ok;
    field_index_next      = field_index;
    char_count_next       = char_count;
    field_first_char_next = field_first_char;
    time_shift_next       = time_shift;
    time_digit_count_next = time_digit_count;
    time_done_next        = time_done;
    lat_accum_next        = lat_accum;
    lat_south_next        = lat_south;
    lon_accum_next        = lon_accum;
    lon_west_next         = lon_west;
    alt_accum_next        = alt_accum;
    alt_negative_next     = alt_negative;
    alt_done_next         = alt_done;
    alt_kilometre_next    = alt_kilometre;
    star_hit              = 1'b0;
    if (in_fire) begin
      if (s_tdata == gga_pkg::CHAR_DOLLAR) begin
        in_sentence_next      = 1'b1;
        header_pos_next       = 3'd1;
        header_ok_next        = 1'b1;
        field_index_next      = 4'd0;
        char_count_next       = 8'd1;
        field_first_char_next = 1'b1;
        time_shift_next       = '0;
        time_digit_count_next = '0;
        time_done_next        = 1'b0;
        lat_accum_next        = '0;
        lat_south_next        = 1'b0;
        lon_accum_next        = '0;
        lon_west_next         = 1'b0;
        alt_accum_next        = '0;
        alt_negative_next     = 1'b0;
        alt_done_next         = 1'b0;
        alt_kilometre_next    = 1'b0;
      end else if (in_sentence) begin
        if (s_tdata == gga_pkg::CHAR_STAR) begin
          in_sentence_next = 1'b0;
          star_hit         = 1'b1;
        end else if (char_count < 8'(gga_pkg::ScanLimit)) begin
          char_count_next = char_count + 8'd1;
          if (header_pos < gga_pkg::HEADER_LEN) begin
            if (s_tdata != gga_pkg::header_char(header_pos)) header_ok_next = 1'b0;
            header_pos_next = header_pos + 3'd1;
          end else if (s_tdata == gga_pkg::CHAR_COMMA) begin
            if (field_index < 4'(gga_pkg::FieldLimit)) field_index_next = field_index + 4'd1;
            field_first_char_next = 1'b1;
          end else begin
            field_first_char_next = 1'b0;
            case (field_index)
              gga_pkg::FIELD_TIME: begin
                if (!time_done) begin
                  if (s_tdata == gga_pkg::CHAR_DOT) begin
                    time_done_next = 1'b1;
                  end else if (time_digit_count < gga_pkg::TIME_DIGITS) begin
                    time_shift_next       = {time_shift[19:0], digit};
                    time_digit_count_next = time_digit_count + 3'd1;
                  end
                end
              end
              gga_pkg::FIELD_LAT: begin
                if (s_tdata != gga_pkg::CHAR_DOT) begin
                  lat_accum_next = gga_pkg::coord_push(lat_accum, digit);
                end
              end
              gga_pkg::FIELD_LAT_HEMI: begin
                if (field_first_char) begin
                  lat_south_next = (s_tdata == gga_pkg::CHAR_UP_S) ||
                                   (s_tdata == gga_pkg::CHAR_LO_S);
                end
              end
              gga_pkg::FIELD_LON: begin
                if (s_tdata != gga_pkg::CHAR_DOT) begin
                  lon_accum_next = gga_pkg::coord_push(lon_accum, digit);
                end
              end
              gga_pkg::FIELD_LON_HEMI: begin
                if (field_first_char) begin
                  lon_west_next = (s_tdata == gga_pkg::CHAR_UP_W) ||
                                  (s_tdata == gga_pkg::CHAR_LO_W);
                end
              end
              gga_pkg::FIELD_ALT: begin
                if (!alt_done) begin
                  if (s_tdata == gga_pkg::CHAR_DOT) begin
                    alt_done_next = 1'b1;
                  end else if (field_first_char && s_tdata == gga_pkg::CHAR_MINUS) begin
                    alt_negative_next = 1'b1;
                  end else begin
                    alt_accum_next = gga_pkg::acc_push(alt_accum, digit);
                  end
                end
              end
              gga_pkg::FIELD_ALT_UNIT: begin
                if (field_first_char) begin
                  alt_kilometre_next = (s_tdata == gga_pkg::CHAR_UP_K) ||
                                       (s_tdata == gga_pkg::CHAR_LO_K);
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence      <= 1'b0;
      header_pos       <= '0;
      header_ok        <= 1'b0;
      field_index      <= '0;
      char_count       <= '0;
      field_first_char <= 1'b1;
      time_shift       <= '0;
      time_digit_count <= '0;
      time_done        <= 1'b0;
      lat_accum        <= '0;
      lat_south        <= 1'b0;
      lon_accum        <= '0;
      lon_west         <= 1'b0;
      alt_accum        <= '0;
      alt_negative     <= 1'b0;
      alt_done         <= 1'b0;
      alt_kilometre    <= 1'b0;
    end else begin
      in_sentence      <= in_sentence_next;
      header_pos       <= header_pos_next;
      header_ok        <= header_ok_next;
      field_index      <= field_index_next;
      char_count       <= char_count_next;
      field_first_char <= field_first_char_next;
      time_shift       <= time_shift_next;
      time_digit_count <= time_digit_count_next;
      time_done        <= time_done_next;
      lat_accum        <= lat_accum_next;
      lat_south        <= lat_south_next;
      lon_accum        <= lon_accum_next;
      lon_west         <= lon_west_next;
      alt_accum        <= alt_accum_next;
      alt_negative     <= alt_negative_next;
      alt_done         <= alt_done_next;
      alt_kilometre    <= alt_kilometre_next;
    end
  end

  assign ready3   = !m_tvalid || m_tready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;

  always_comb begin
    if (!header_ok || header_pos < gga_pkg::HEADER_LEN) begin
      status_now = gga_pkg::STATUS_BAD_HEADER;
    end else if (field_index < gga_pkg::FIELDS_NEEDED) begin
      status_now = gga_pkg::STATUS_SHORT;
    end else begin
      status_now = gga_pkg::STATUS_DECODED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= star_hit;
    end
    if (star_hit) begin
      p1_status  <= status_now;
      p1_time    <= time_shift << {gga_pkg::TIME_DIGITS - time_digit_count, 2'b00};
      p1_lat     <= lat_accum;
      p1_lat_neg <= lat_south;
      p1_lon     <= lon_accum;
      p1_lon_neg <= lon_west;
      p1_alt     <= alt_accum;
      p1_alt_km  <= alt_kilometre;
      p1_alt_neg <= alt_negative;
    end
  end

  assign lat_x5   = {1'b0, p1_lat.minutes, 2'b00} + {3'b0, p1_lat.minutes};
  assign lon_x5   = {1'b0, p1_lon.minutes, 2'b00} + {3'b0, p1_lon.minutes};
  assign lat_prod = {23'b0, lat_x5} * {23'b0, gga_pkg::RECIP_THREE};
  assign lon_prod = {23'b0, lon_x5} * {23'b0, gga_pkg::RECIP_THREE};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
    if (ready2 && v1) begin
      p2_status   <= p1_status;
      p2_time     <= p1_time;
      p2_lat_deg  <= {20'b0, p1_lat.degrees} * 30'(gga_pkg::MinuteScale);
      p2_lat_frac <= lat_prod[44:24];
      p2_lat_neg  <= p1_lat_neg;
      p2_lon_deg  <= {20'b0, p1_lon.degrees} * 30'(gga_pkg::MinuteScale);
      p2_lon_frac <= lon_prod[44:24];
      p2_lon_neg  <= p1_lon_neg;
      p2_alt      <= p1_alt_km ? {10'b0, p1_alt} * 40'd1000 : {10'b0, p1_alt};
      p2_alt_neg  <= p1_alt_neg;
    end
  end

  assign lat_out = gga_pkg::signed_out({10'b0, p2_lat_deg} + {19'b0, p2_lat_frac}, p2_lat_neg);
  assign lon_out = gga_pkg::signed_out({10'b0, p2_lon_deg} + {19'b0, p2_lon_frac}, p2_lon_neg);
  assign alt_out = gga_pkg::signed_out(p2_alt, p2_alt_neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready3) begin
      m_tvalid <= v2;
    end
    if (ready3 && v2) begin
      if (p2_status == gga_pkg::STATUS_DECODED) begin
        m_tdata <= {1'b0, alt_out, lon_out, lat_out, p2_time, p2_status};
      end else begin
        m_tdata <= {118'b0, p2_status};
      end
    end
  end

endmodule

/* dv/gga_sentence_position_decoder_top_tb.sv */
// Testbench for the GGA sentence position decoder: NMEA byte streams checked by a byte predictor.
module gga_sentence_position_decoder_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int RandomBytes = 550;
  localparam logic [47:0] HDR_TEXT = "$GPGGA";

  typedef struct packed {
    logic signed [30:0] altitude;
    logic signed [30:0] longitude;
    logic signed [30:0] latitude;
    logic [23:0]        utc_time_bcd;
    logic [1:0]         status;
  } gga_fix_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;

  gga_fix_t   expected_fixes[$];
  logic [7:0] gga_line[$];
  int         mismatch_count;
  int         cycle_count;
  int         bytes_sent;
  int         burst_left;
  bit         sender_gaps;

  bit               pr_in_sentence;
  logic [2:0]       pr_header_pos;
  bit               pr_header_ok;
  logic [3:0]       pr_field;
  int unsigned      pr_char_count;
  bit               pr_first;
  logic [23:0]      pr_time;
  logic [2:0]       pr_time_digits;
  bit               pr_time_done;
  longint unsigned  pr_lat;
  bit               pr_south;
  longint unsigned  pr_lon;
  bit               pr_west;
  longint unsigned  pr_alt;
  bit               pr_alt_neg;
  bit               pr_alt_done;
  bit               pr_alt_km;

  gga_sentence_position_decoder_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      case ((cycle_count / 250) % 4)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 3) != 0);
        2:       m_tready <= (cycle_count % 24 == 0);
        default: m_tready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  function automatic int unsigned digit_of(logic [7:0] b);
    return (b >= gga_pkg::CHAR_ZERO && b <= gga_pkg::CHAR_NINE) ? b - gga_pkg::CHAR_ZERO : 0;
  endfunction

  function automatic longint unsigned push_decimal(longint unsigned acc, logic [7:0] b);
    longint unsigned v;
    v = acc * 10 + digit_of(b);
    return (v > gga_pkg::ACC_MAX) ? gga_pkg::ACC_MAX : v;
  endfunction

  function automatic logic signed [30:0] fold_sign(longint unsigned mag, bit neg);
    logic [30:0] m;
    if (mag > gga_pkg::ACC_MAX) mag = gga_pkg::ACC_MAX;
    m = mag[30:0];
    return neg ? -m : m;
  endfunction

  function automatic logic signed [30:0] coord_value(longint unsigned acc, bit neg);
    longint unsigned deg;
    longint unsigned minp;
    deg = acc / 1000000;
    minp = acc % 1000000;
    return fold_sign(deg * 1000000 + (minp * 100) / 60, neg);
  endfunction

  function automatic void open_sentence();
    pr_in_sentence = 1'b1;
    pr_header_pos = 3'd1;
    pr_header_ok = 1'b1;
    pr_field = '0;
    pr_char_count = 1;
    pr_first = 1'b1;
    pr_time = '0;
    pr_time_digits = '0;
    pr_time_done = 1'b0;
    pr_lat = 0;
    pr_south = 1'b0;
    pr_lon = 0;
    pr_west = 1'b0;
    pr_alt = 0;
    pr_alt_neg = 1'b0;
    pr_alt_done = 1'b0;
    pr_alt_km = 1'b0;
  endfunction

  function automatic void reset_parser();
    open_sentence();
    pr_in_sentence = 1'b0;
    pr_header_pos = '0;
    pr_header_ok = 1'b0;
    pr_char_count = 0;
  endfunction

  function automatic bit gga_parse_byte(input logic [7:0] b, output gga_fix_t fix);
    bit first;
    longint unsigned alt_mag;
    fix = '0;
    if (b == gga_pkg::CHAR_DOLLAR) begin
      open_sentence();
      return 1'b0;
    end
    if (!pr_in_sentence) return 1'b0;
    if (b == gga_pkg::CHAR_STAR) begin
      pr_in_sentence = 1'b0;
      if (!pr_header_ok || pr_header_pos < gga_pkg::HEADER_LEN) begin
        fix.status = gga_pkg::STATUS_BAD_HEADER;
      end else if (pr_field < gga_pkg::FIELDS_NEEDED) begin
        fix.status = gga_pkg::STATUS_SHORT;
      end else begin
        fix.status = gga_pkg::STATUS_DECODED;
        fix.utc_time_bcd = pr_time << (4 * (gga_pkg::TIME_DIGITS - pr_time_digits));
        fix.latitude = coord_value(pr_lat, pr_south);
        fix.longitude = coord_value(pr_lon, pr_west);
        alt_mag = pr_alt_km ? pr_alt * 1000 : pr_alt;
        fix.altitude = fold_sign(alt_mag, pr_alt_neg);
      end
      return 1'b1;
    end
    if (pr_char_count >= gga_pkg::ScanLimit) return 1'b0;
    pr_char_count++;
    if (pr_header_pos < gga_pkg::HEADER_LEN) begin
      if (b != HDR_TEXT[8 * (5 - pr_header_pos) +: 8]) pr_header_ok = 1'b0;
      pr_header_pos++;
      return 1'b0;
    end
    if (b == gga_pkg::CHAR_COMMA) begin
      if (pr_field < gga_pkg::FieldLimit) pr_field++;
      pr_first = 1'b1;
      return 1'b0;
    end
    first = pr_first;
    pr_first = 1'b0;
    case (pr_field)
      gga_pkg::FIELD_TIME: begin
        if (!pr_time_done) begin
          if (b == gga_pkg::CHAR_DOT) begin
            pr_time_done = 1'b1;
          end else if (pr_time_digits < gga_pkg::TIME_DIGITS) begin
            pr_time = {pr_time[19:0], 4'(digit_of(b))};
            pr_time_digits++;
          end
        end
      end
      gga_pkg::FIELD_LAT: if (b != gga_pkg::CHAR_DOT) pr_lat = push_decimal(pr_lat, b);
      gga_pkg::FIELD_LAT_HEMI:
        if (first) pr_south = (b == gga_pkg::CHAR_UP_S || b == gga_pkg::CHAR_LO_S);
      gga_pkg::FIELD_LON: if (b != gga_pkg::CHAR_DOT) pr_lon = push_decimal(pr_lon, b);
      gga_pkg::FIELD_LON_HEMI:
        if (first) pr_west = (b == gga_pkg::CHAR_UP_W || b == gga_pkg::CHAR_LO_W);
      gga_pkg::FIELD_ALT: begin
        if (!pr_alt_done) begin
          if (b == gga_pkg::CHAR_DOT) pr_alt_done = 1'b1;
          else if (first && b == gga_pkg::CHAR_MINUS) pr_alt_neg = 1'b1;
          else pr_alt = push_decimal(pr_alt, b);
        end
      end
      gga_pkg::FIELD_ALT_UNIT:
        if (first) pr_alt_km = (b == gga_pkg::CHAR_UP_K || b == gga_pkg::CHAR_LO_K);
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < 40)
      $display("mismatch %s: got %0d expected %0d, cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    gga_fix_t got;
    gga_fix_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[1:0];
      got.utc_time_bcd = m_tdata[25:2];
      got.latitude = m_tdata[56:26];
      got.longitude = m_tdata[87:57];
      got.altitude = m_tdata[118:88];
      if (expected_fixes.size() == 0) begin
        report_mismatch("unexpected result transaction", got.status, 0);
      end else begin
        want = expected_fixes.pop_front();
        if (got.status != want.status)
          report_mismatch("status", got.status, want.status);
        if (got.utc_time_bcd != want.utc_time_bcd)
          report_mismatch("utc_time_bcd", got.utc_time_bcd, want.utc_time_bcd);
        if (got.latitude != want.latitude)
          report_mismatch("latitude", got.latitude, want.latitude);
        if (got.longitude != want.longitude)
          report_mismatch("longitude", got.longitude, want.longitude);
        if (got.altitude != want.altitude)
          report_mismatch("altitude", got.altitude, want.altitude);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gga_fix_t fix;
    @(negedge clk);
    gap = 0;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    if (gga_parse_byte(b, fix)) begin
      expected_fixes.push_back(fix);
    end
    bytes_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) gga_line.push_back(s[i]);
  endtask

  task automatic add_choice(input string s);
    gga_line.push_back(s[$urandom_range(0, s.len() - 1)]);
  endtask

  task automatic add_digits(input int n, input int noise_pct);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        b = 8'($urandom_range(0, 255));
        if (b == gga_pkg::CHAR_DOLLAR || b == gga_pkg::CHAR_STAR || b == gga_pkg::CHAR_COMMA)
          b = "x";
      end else begin
        b = gga_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
      end
      gga_line.push_back(b);
    end
  endtask

  task automatic send_line();
    foreach (gga_line[i]) send_byte(gga_line[i]);
    gga_line.delete();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_line();
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (expected_fixes.size() == 0);
  endtask

  task automatic test_reference_sentences();
    sender_gaps = 1'b0;
    send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");
    send_text("$GPGGA,12,0000.0000,N,00000.0000,E,1,08,0.9,0,M,,,,*00\r\n");
    send_text("$GPGGA,1234567.89,4807.038,n,01131.000,e,1,08,0.9,545.4,m,46.9,M,,*47\r\n");
  endtask

  task automatic test_signs_and_units();
    sender_gaps = 1'b1;
    send_text("$GPGGA,235959.99,8959.9999,S,17959.9999,W,1,12,0.5,-12.5,K,0,M,,*00\r\n");
    send_text("$GPGGA,000000,0130.5,s,00030.5,w,2,04,1.5,-0.7,k,,,,*11\r\n");
    wait_results_drained();
  endtask

  task automatic test_saturation();
    send_text("$GPGGA,999999,99999999999,S,99999999999,W,,,,99999999,K,,,,*1F\r\n");
    send_text("$GPGGA,,99959.9999,N,99959.9999,E,,,,999999999999,M,*\r\n");
  endtask

  task automatic test_malformed_sentences();
    send_text("xyz*\r\n");
    send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,,,,,,*6A\r\n");
    send_text("$GP*");
    send_text("$*");
    send_text("$GPGGA,1,2,N,3,E,1,2,3*");
    send_text("$GPGGA,12$GPGGA,101010,1234.5,N,12345.6,E,1,2,3,4,M,*");
    send_text("$GPGGAJUNK,1a:5,48x7.0,N,0F1.2,E,,,,1-2.9,M,*");
    send_text("$GPGGA,,,,,,,,,-,K*");
  endtask

  task automatic test_long_sentences();
    add_text("$GPGGA,1,2,N,3,E,,,,");
    repeat (120) gga_line.push_back(gga_pkg::CHAR_NINE);
    add_text(",K*");
    send_line();
    add_text("$GPGGA");
    repeat (20) gga_line.push_back(gga_pkg::CHAR_COMMA);
    add_text("*");
    send_line();
    add_text("$GPGGA,1");
    add_digits(140, 30);
    add_text("$GPGGA,1,2,S,3,W,,,,4,k,*");
    send_line();
    wait_results_drained();
  endtask

  task automatic add_random_sentence();
    int kind;
    int nfields;
    int r;
    string hdr;
    hdr = "GPGGA";
    kind = $urandom_range(0, 99);
    gga_line.push_back(gga_pkg::CHAR_DOLLAR);
    if (kind < 15) begin
      r = $urandom_range(0, 5);
      for (int i = 0; i < r; i++) gga_line.push_back(hdr[i]);
      gga_line.push_back(gga_pkg::CHAR_STAR);
    end else begin
      add_text(hdr);
      if (kind < 22) gga_line[$urandom_range(1, 5)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) add_digits($urandom_range(1, 3), 50);
      nfields = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 14;
      for (int f = 1; f <= nfields; f++) begin
        gga_line.push_back(gga_pkg::CHAR_COMMA);
        r = $urandom_range(0, 19);
        case (f)
          gga_pkg::FIELD_TIME: begin
            add_digits($urandom_range(0, 8), 3);
            if (r < 10) begin
              gga_line.push_back(gga_pkg::CHAR_DOT);
              add_digits($urandom_range(0, 3), 3);
            end
          end
          gga_pkg::FIELD_LAT, gga_pkg::FIELD_LON: begin
            add_digits((r == 0) ? $urandom_range(5, 12) : $urandom_range(0, 5), 3);
            if (r < 16) begin
              gga_line.push_back(gga_pkg::CHAR_DOT);
              add_digits($urandom_range(0, 5), 3);
            end
          end
          gga_pkg::FIELD_LAT_HEMI: begin
            if (r < 17) add_choice("NSsn");
            else if (r == 19) add_digits(1, 100);
          end
          gga_pkg::FIELD_LON_HEMI: begin
            if (r < 17) add_choice("EWwe");
            else if (r == 19) add_digits(1, 100);
          end
          gga_pkg::FIELD_ALT: begin
            if (r < 7) gga_line.push_back(gga_pkg::CHAR_MINUS);
            add_digits((r == 19) ? $urandom_range(6, 11) : $urandom_range(0, 5), 3);
            if ($urandom_range(0, 9) < 6) begin
              gga_line.push_back(gga_pkg::CHAR_DOT);
              add_digits($urandom_range(0, 3), 3);
            end
          end
          gga_pkg::FIELD_ALT_UNIT: begin
            if (r < 18) add_choice("MKkm");
            else if (r == 19) add_digits(1, 100);
          end
          default: begin
            add_digits($urandom_range(0, 3), 5);
            if (f == 7 && r == 0) add_digits(80, 5);
          end
        endcase
      end
      if ($urandom_range(0, 9) != 0) begin
        gga_line.push_back(gga_pkg::CHAR_STAR);
        add_choice("0123456789ABCDEF");
        add_choice("0123456789ABCDEF");
        add_text("\r\n");
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) gga_line.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic();
    int start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RandomBytes) begin
      sender_gaps = ($urandom_range(0, 4) != 0);
      add_random_sentence();
      send_line();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sender_gaps = 1'b0;
    burst_left = 0;
    mismatch_count = 0;
    cycle_count = 0;
    bytes_sent = 0;
    reset_parser();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reference_sentences();
    test_signs_and_units();
    test_saturation();
    test_malformed_sentences();
    test_long_sentences();
    test_random_traffic();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (expected_fixes.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* gga_sentence_position_decoder_top.f */
src/gga_pkg.sv
src/gga_sentence_position_decoder_top.sv
dv/gga_sentence_position_decoder_top_tb.sv
